// ===== rtl/mmrd_pkg.sv =====
`default_nettype none
package mmrd_pkg;

    localparam int MAX_FRAME_BYTES = 64;
    localparam int MIN_FRAME_BYTES = 17;
    localparam int FIELD_FIRST     = 3;
    localparam int FIELD_COUNT     = 12;

    localparam int COUNT_W     = $clog2(MAX_FRAME_BYTES + 1);
    localparam int FIELD_IDX_W = $clog2(FIELD_COUNT);

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam int          PADDR_W            = 3;
    localparam logic [7:0]  DEVICE_ADDR_RESET  = 8'd1;
    localparam logic [0:0]  REG_DEVICE_ADDRESS = 1'd0;

    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_BAD_ADDR = 3'd1,
        STATUS_CRC_ERR  = 3'd2,
        STATUS_SHORT    = 3'd3,
        STATUS_LONG     = 3'd4
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] voltage;
        logic [15:0] current;
        logic [15:0] power;
        logic [31:0] energy;
        logic [15:0] power_factor;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/mmrd_apb_regs.sv =====
`default_nettype none
module mmrd_apb_regs
    import mmrd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output logic      [7:0]         device_address
);

    logic [7:0] dev_addr_reg;
    logic       reg_hit;

    // word index is the upper address bit; byte lanes ignored
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_DEVICE_ADDRESS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= DEVICE_ADDR_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            dev_addr_reg <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_hit) begin
            prdata = {24'd0, dev_addr_reg};
        end
    end

    assign pready         = 1'b1;
    assign device_address = dev_addr_reg;

endmodule
`default_nettype wire

// ===== rtl/mmrd_crc16.sv =====
`default_nettype none
module mmrd_crc16
    import mmrd_pkg::*;
(
    input  wire logic [15:0] crc_in,
    input  wire logic [7:0]  data_in,
    output logic      [15:0] crc_out
);

    // reflected CRC-16, one byte unrolled into eight shift/xor steps
    always_comb begin
        logic [15:0] c;
        c = crc_in ^ {8'd0, data_in};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule
`default_nettype wire

// ===== rtl/mmrd_frame_core.sv =====
`default_nettype none
module mmrd_frame_core
    import mmrd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       accept,
    input  wire logic [7:0] rx_byte,
    input  wire logic       end_of_frame,
    input  wire logic [7:0] device_address,
    output logic            done,
    output result_t         result
);

    logic [15:0]        crc_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [7:0]         held0_reg;
    logic [7:0]         held1_reg;
    logic               addr_match_reg;
    logic               overflow_reg;
    logic [7:0]         field_reg [FIELD_COUNT];

    logic [15:0]          crc_fed;
    logic [15:0]          crc_next;
    logic [COUNT_W-1:0]   len;
    logic                 at_max;
    logic [COUNT_W-1:0]   count_next;
    logic                 overflow_next;
    logic                 addr_match_next;
    logic                 field_wr;
    logic [COUNT_W-1:0]   field_off;
    logic [FIELD_IDX_W-1:0] field_idx;
    status_t              status;

    mmrd_crc16 u_crc (
        .crc_in  (crc_reg),
        .data_in (held0_reg),
        .crc_out (crc_fed)
    );

    // crc trails the input by two bytes so the trailer is never folded in
    assign crc_next = (count_reg >= COUNT_W'(2)) ? crc_fed : crc_reg;

    assign len           = count_reg + COUNT_W'(1);
    assign at_max        = (len >= COUNT_W'(MAX_FRAME_BYTES));
    assign count_next    = at_max ? COUNT_W'(MAX_FRAME_BYTES) : len;
    assign overflow_next = overflow_reg | at_max;
    assign addr_match_next = (count_reg == '0) ? (rx_byte == device_address)
                                               : addr_match_reg;

    assign field_wr  = (count_reg >= COUNT_W'(FIELD_FIRST)) &&
                       (count_reg <  COUNT_W'(FIELD_FIRST + FIELD_COUNT));
    assign field_off = count_reg - COUNT_W'(FIELD_FIRST);
    assign field_idx = field_off[FIELD_IDX_W-1:0];

    always_comb begin
        if (overflow_next) begin
            status = STATUS_LONG;
        end else if (len < COUNT_W'(MIN_FRAME_BYTES)) begin
            status = STATUS_SHORT;
        end else if (!addr_match_next) begin
            status = STATUS_BAD_ADDR;
        end else if (crc_next != {rx_byte, held1_reg}) begin
            status = STATUS_CRC_ERR;
        end else begin
            status = STATUS_OK;
        end
    end

    // field bytes are only shown on a good frame, which wrote all of them
    always_comb begin
        result        = '0;
        result.status = status;
        if (status == STATUS_OK) begin
            result.voltage      = {field_reg[0], field_reg[1]};
            result.current      = {field_reg[2], field_reg[3]};
            result.power        = {field_reg[4], field_reg[5]};
            result.energy       = {field_reg[6], field_reg[7], field_reg[8], field_reg[9]};
            result.power_factor = {field_reg[10], field_reg[11]};
        end
    end

    assign done = accept && end_of_frame;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg        <= CRC_INIT;
            count_reg      <= '0;
            held0_reg      <= '0;
            held1_reg      <= '0;
            addr_match_reg <= 1'b0;
            overflow_reg   <= 1'b0;
        end else if (accept) begin
            if (end_of_frame) begin
                crc_reg        <= CRC_INIT;
                count_reg      <= '0;
                held0_reg      <= '0;
                held1_reg      <= '0;
                addr_match_reg <= 1'b0;
                overflow_reg   <= 1'b0;
            end else begin
                crc_reg        <= crc_next;
                count_reg      <= count_next;
                held0_reg      <= held1_reg;
                held1_reg      <= rx_byte;
                addr_match_reg <= addr_match_next;
                overflow_reg   <= overflow_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && field_wr) begin
            field_reg[field_idx] <= rx_byte;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(MAX_FRAME_BYTES))
        else $error("byte count beyond frame limit");

    a_overflow_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        overflow_reg |-> (count_reg == COUNT_W'(MAX_FRAME_BYTES)))
        else $error("overflow flag without saturated count");

    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> (count_reg == '0) && (crc_reg == CRC_INIT) && !overflow_reg)
        else $error("frame state not cleared after frame end");

    a_crc_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !end_of_frame && count_reg < COUNT_W'(2)) |=> (crc_reg == CRC_INIT))
        else $error("crc advanced during the first two bytes");

endmodule
`default_nettype wire

// ===== rtl/modbus_meter_response_decoder.sv =====
`default_nettype none
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_rx_byte[7:0], s_end_of_frame
// m_        out        m_valid/m_ready    m_status[2:0], m_voltage, m_current, m_power,
//                                         m_energy[31:0], m_power_factor
// APB       in/out     psel/penable       device_address at byte 0
//
// One byte per cycle while s_ready is high; the byte-wide CRC update, length and address
// checks sit between the frame state registers and the result register.
// The result beat appears the cycle after its last byte is taken.
// Synchronous active-low reset clears frame state; device_address resets to 1.
// s_ready drops only while a result beat is held and m_ready is low.
module modbus_meter_response_decoder
    import mmrd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_rx_byte,
    input  wire logic               s_end_of_frame,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [2:0]         m_status,
    output logic      [15:0]        m_voltage,
    output logic      [15:0]        m_current,
    output logic      [15:0]        m_power,
    output logic      [31:0]        m_energy,
    output logic      [15:0]        m_power_factor
);

    logic       [7:0] device_address;
    logic             accept;
    logic             done;
    result_t          result;
    result_t          result_reg;
    logic             m_valid_reg;

    mmrd_apb_regs u_regs (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .device_address (device_address)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    mmrd_frame_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .rx_byte        (s_rx_byte),
        .end_of_frame   (s_end_of_frame),
        .device_address (device_address),
        .done           (done),
        .result         (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            result_reg <= result;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = result_reg.status;
    assign m_voltage      = result_reg.voltage;
    assign m_current      = result_reg.current;
    assign m_power        = result_reg.power;
    assign m_energy       = result_reg.energy;
    assign m_power_factor = result_reg.power_factor;

endmodule
`default_nettype wire
